// ===== rtl/bpa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the page allocator.
package bpa_pkg;

  // Allocator geometry
  localparam int MAX_ORDER  = 16;
  localparam int PAGE_ORDER = 8;
  localparam int LIST_DEPTH = 16;

  localparam int NUM_ORDERS = MAX_ORDER + 1;
  localparam int ORD_W      = 5;
  localparam int ADDR_W     = 32;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int MEM_DEPTH  = NUM_ORDERS * LIST_DEPTH;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);
  localparam int CFG_IDX_W  = 1;

  // Operation codes
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_BIG  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_START = 1'd0,
    REG_HEAP_END   = 1'd1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_SEARCH,
    S_READ,
    S_SPLIT,
    S_FREE,
    S_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    capture;      // latch transaction fields, clear result
    logic    init_begin;   // empty all lists, round start, go to top order
    logic    ord_from_req; // working order <= requested order
    logic    init_place;   // place a block at working order if it fits
    logic    ord_inc;
    logic    ord_dec;
    logic    pop;          // pop top of working order list
    logic    load_base;    // take popped base from memory
    logic    split_push;   // push upper half one order down, step down
    logic    grant;        // granted base <= working base
    logic    free_push;    // push freed base, flag full list
    logic    set_status;
    status_t status_val;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       ord_big;
    logic       cnt_zero;
    logic       ord_at_max;
    logic       ord_at_page;
    logic       ord_at_req;
  } sts_t;

endpackage

// ===== rtl/bpa_ctrl.sv =====
// Controller state machine sequencing init, allocate and free transactions.
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output bpa_pkg::cmd_t cmd,
  input  bpa_pkg::sts_t sts
);

  bpa_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.status_val = bpa_pkg::ST_OK;
    busy           = 1'b1;
    done           = 1'b0;
    case (state)
      bpa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = bpa_pkg::S_DECODE;
        end
      end
      bpa_pkg::S_DECODE: begin
        case (bpa_pkg::op_t'(sts.op))
          bpa_pkg::OP_INIT: begin
            cmd.init_begin = 1'b1;
            state_next     = bpa_pkg::S_INIT;
          end
          bpa_pkg::OP_ALLOC, bpa_pkg::OP_FREE: begin
            if (sts.ord_big) begin
              cmd.set_status = 1'b1;
              cmd.status_val = bpa_pkg::ST_BIG;
              state_next     = bpa_pkg::S_RESP;
            end else begin
              cmd.ord_from_req = 1'b1;
              state_next       = (bpa_pkg::op_t'(sts.op) == bpa_pkg::OP_ALLOC) ?
                                 bpa_pkg::S_SEARCH : bpa_pkg::S_FREE;
            end
          end
          default: begin
            state_next = bpa_pkg::S_RESP;
          end
        endcase
      end
      // one order per cycle, top down
      bpa_pkg::S_INIT: begin
        cmd.init_place = 1'b1;
        if (sts.ord_at_page) begin
          state_next = bpa_pkg::S_RESP;
        end else begin
          cmd.ord_dec = 1'b1;
        end
      end
      // walk up to the first non-empty list, or report OOM at the top order
      bpa_pkg::S_SEARCH: begin
        if (!sts.cnt_zero) begin
          cmd.pop    = 1'b1;
          state_next = bpa_pkg::S_READ;
        end else if (sts.ord_at_max) begin
          cmd.set_status = 1'b1;
          cmd.status_val = bpa_pkg::ST_OOM;
          state_next     = bpa_pkg::S_RESP;
        end else begin
          cmd.ord_inc = 1'b1;
        end
      end
      bpa_pkg::S_READ: begin
        cmd.load_base = 1'b1;
        state_next    = bpa_pkg::S_SPLIT;
      end
      // split down to the requested order
      bpa_pkg::S_SPLIT: begin
        if (sts.ord_at_req) begin
          cmd.grant  = 1'b1;
          state_next = bpa_pkg::S_RESP;
        end else begin
          cmd.split_push = 1'b1;
        end
      end
      bpa_pkg::S_FREE: begin
        cmd.free_push = 1'b1;
        state_next    = bpa_pkg::S_RESP;
      end
      bpa_pkg::S_RESP: begin
        done       = 1'b1;
        state_next = bpa_pkg::S_IDLE;
      end
      default: begin
        state_next = bpa_pkg::S_IDLE;
      end
    endcase
  end

  // Checks
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not start work");
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.ord_inc |-> !sts.ord_at_max)
    else $error("search stepped past the largest order");

endmodule

// ===== rtl/bpa_dpath.sv =====
// Datapath: free-list memory, per-order counts, config registers and result registers.
module bpa_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    op,
  input  logic [bpa_pkg::ORD_W-1:0]     order,
  input  logic [bpa_pkg::ADDR_W-1:0]    block_base,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata,
  input  bpa_pkg::cmd_t                 cmd,
  output bpa_pkg::sts_t                 sts,
  output logic [1:0]                    status,
  output logic [bpa_pkg::ADDR_W-1:0]    granted_base,
  output logic [bpa_pkg::ORD_W-1:0]     granted_order
);

  localparam int CW = bpa_pkg::ADDR_W + 1;  // running carve address, no wrap
  localparam logic [CW-1:0] PAGE_MASK = (CW'(1) << bpa_pkg::PAGE_ORDER) - CW'(1);

  logic [bpa_pkg::ADDR_W-1:0] heap_start;
  logic [bpa_pkg::ADDR_W-1:0] heap_end;
  logic [1:0]                 op_q;
  logic [bpa_pkg::ORD_W-1:0]  req_ord;
  logic [bpa_pkg::ADDR_W-1:0] free_base;
  logic [bpa_pkg::ORD_W-1:0]  cur_ord;
  logic [bpa_pkg::ADDR_W-1:0] base;
  logic [CW-1:0]              cur;
  logic [1:0]                 status_q;
  logic [bpa_pkg::ADDR_W-1:0] granted;
  logic [bpa_pkg::CNT_W-1:0]  cnt [bpa_pkg::NUM_ORDERS];

  logic [bpa_pkg::ADDR_W-1:0] mem [bpa_pkg::MEM_DEPTH];
  logic [bpa_pkg::ADDR_W-1:0] rdata;

  logic [bpa_pkg::ORD_W-1:0]  ord_below;
  logic [bpa_pkg::ORD_W-1:0]  cnt_idx;
  logic [bpa_pkg::CNT_W-1:0]  cnt_rd;
  logic                       cnt_full;
  logic [bpa_pkg::MEM_AW-1:0] row_addr;
  logic [bpa_pkg::MEM_AW-1:0] push_addr;
  logic [bpa_pkg::MEM_AW-1:0] pop_addr;
  logic [bpa_pkg::CNT_W-1:0]  cnt_dec;
  logic [CW-1:0]              cur_end;
  logic                       fits;
  logic [CW-1:0]              start_rnd;
  logic                       mem_we;
  logic [bpa_pkg::ADDR_W-1:0] mem_wdata;
  logic                       cnt_inc;

  // Count lookup: one list per cycle, the one below during a split
  always_comb begin
    ord_below = cur_ord - bpa_pkg::ORD_W'(1);
    cnt_idx   = cmd.split_push ? ord_below : cur_ord;
    cnt_rd    = cnt[cnt_idx];
    cnt_dec   = cnt_rd - bpa_pkg::CNT_W'(1);
    cnt_full  = (cnt_rd >= bpa_pkg::CNT_W'(bpa_pkg::LIST_DEPTH));
    row_addr  = bpa_pkg::MEM_AW'(bpa_pkg::MEM_AW'(cnt_idx) *
                                 bpa_pkg::MEM_AW'(bpa_pkg::LIST_DEPTH));
    push_addr = row_addr + bpa_pkg::MEM_AW'(cnt_rd[bpa_pkg::IDX_W-1:0]);
    pop_addr  = row_addr + bpa_pkg::MEM_AW'(cnt_dec[bpa_pkg::IDX_W-1:0]);
  end

  // Init carve arithmetic
  always_comb begin
    start_rnd = ({1'b0, heap_start} + PAGE_MASK) & ~PAGE_MASK;
    cur_end   = cur + (CW'(1) << cur_ord);
    fits      = (cur_end <= {1'b0, heap_end});
  end

  // Memory write selection
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = base + (bpa_pkg::ADDR_W'(1) << ord_below);
    cnt_inc   = 1'b0;
    if (cmd.init_place && fits) begin
      mem_we    = 1'b1;
      mem_wdata = cur[bpa_pkg::ADDR_W-1:0];
      cnt_inc   = 1'b1;
    end else if (cmd.split_push) begin
      mem_we    = 1'b1;
      cnt_inc   = 1'b1;
    end else if (cmd.free_push && !cnt_full) begin
      mem_we    = 1'b1;
      mem_wdata = free_base;
      cnt_inc   = 1'b1;
    end
  end

  // Free-list memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[push_addr] <= mem_wdata;
    end
    rdata <= mem[pop_addr];
  end

  // Per-order counts
  always_ff @(posedge clk) begin
    if (rst || cmd.init_begin) begin
      for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) begin
        cnt[i] <= '0;
      end
    end else if (cnt_inc) begin
      cnt[cnt_idx] <= cnt_rd + bpa_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      cnt[cnt_idx] <= cnt_dec;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= '0;
      heap_end   <= '0;
    end else if (cfg_we) begin
      case (bpa_pkg::cfg_reg_t'(cfg_index))
        bpa_pkg::REG_HEAP_START: heap_start <= cfg_wdata;
        bpa_pkg::REG_HEAP_END:   heap_end   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Transaction and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= op;
      req_ord   <= order;
      free_base <= block_base;
      status_q  <= bpa_pkg::ST_OK;
      granted   <= '0;
    end
    if (cmd.set_status) begin
      status_q <= cmd.status_val;
    end
    if (cmd.free_push && cnt_full) begin
      status_q <= bpa_pkg::ST_FULL;
    end
    if (cmd.grant) begin
      granted <= base;
    end
    // working order starts at a valid list so the count lookup is defined
    if (rst) begin
      cur_ord <= '0;
    end else if (cmd.init_begin) begin
      cur     <= start_rnd;
      cur_ord <= bpa_pkg::ORD_W'(bpa_pkg::MAX_ORDER);
    end else if (cmd.ord_from_req) begin
      cur_ord <= req_ord;
    end else if (cmd.ord_inc) begin
      cur_ord <= cur_ord + bpa_pkg::ORD_W'(1);
    end else if (cmd.ord_dec || cmd.split_push) begin
      cur_ord <= ord_below;
    end
    if (cmd.init_place && fits) begin
      cur <= cur_end;
    end
    if (cmd.load_base) begin
      base <= rdata;
    end
  end

  // Status to controller
  always_comb begin
    sts.op          = op_q;
    sts.ord_big     = (req_ord > bpa_pkg::ORD_W'(bpa_pkg::MAX_ORDER));
    sts.cnt_zero    = (cnt_rd == '0);
    sts.ord_at_max  = (cur_ord == bpa_pkg::ORD_W'(bpa_pkg::MAX_ORDER));
    sts.ord_at_page = (cur_ord == bpa_pkg::ORD_W'(bpa_pkg::PAGE_ORDER));
    sts.ord_at_req  = (cur_ord == req_ord);
  end

  assign status        = status_q;
  assign granted_base  = granted;
  assign granted_order = req_ord;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_rd <= bpa_pkg::CNT_W'(bpa_pkg::LIST_DEPTH))
    else $error("free list count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> cnt_rd != '0)
    else $error("pop from empty list");
  a_split_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.split_push |-> cnt_rd == '0)
    else $error("split half pushed onto non-empty list");

endmodule

// ===== rtl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: controller plus datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  command  | start / busy        | op, order, block_base
//  result   | done (1-cycle)      | status, granted_base, granted_order
//  config   | cfg_we              | cfg_index, cfg_wdata
//
// One transaction at a time; busy is high from acceptance until done.
// Init, search and split walk the count table one order per cycle. Steps:
//   free: decode, push, respond; invalid op or order too large: decode, respond;
//   init: decode, try one block per order from MAX_ORDER down to PAGE_ORDER,
//   respond; allocate: decode, search up, read, split down, grant, respond.
// Synchronous reset empties all free lists and clears both heap bounds.
// The result is shown for the single cycle done is high; it cannot be held off.
module buddy_page_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic [bpa_pkg::ORD_W-1:0]     order,
  input  logic [bpa_pkg::ADDR_W-1:0]    block_base,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [bpa_pkg::ADDR_W-1:0]    granted_base,
  output logic [bpa_pkg::ORD_W-1:0]     granted_order,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  bpa_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .order         (order),
    .block_base    (block_base),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .granted_base  (granted_base),
    .granted_order (granted_order)
  );

endmodule
